@@ rtl/core/lrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrm_pkg
// Shared widths, register indexes and unit sizes of the loop rate monitor.
// ----------------------------------------------------------------------------
package lrm_pkg;

    // Time stamps and statistics
    localparam int TIME_W   = 63;
    localparam int CNT_W    = 32;
    localparam int AWAKE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int MEAN_W   = AWAKE_W + FRAC_W;
    localparam int M2_W     = 64;
    localparam int LEVEL_W  = 2;

    // Serial divider: mean delta divided by the step count
    localparam int DIV_W    = MEAN_W;
    localparam int DVS_W    = CNT_W;

    // Chunked multiplier: |delta| * |delta2|
    localparam int MUL_W       = MEAN_W;
    localparam int MUL_CHUNK_W = 16;
    localparam int MUL_CHUNKS  = MUL_W / MUL_CHUNK_W;
    localparam int PP_W        = MUL_W + MUL_CHUNK_W;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int PROD_SHIFT  = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENFORCE = 2'd3;

    // Overrun classes
    localparam logic [LEVEL_W-1:0] LEVEL_OK    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WARN  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_ERROR = 2'd2;

    // Reset values of the configuration registers
    localparam logic [31:0] PERIOD_RST = 32'd1000000;
    localparam logic [31:0] WARN_RST   = 32'd1000000;
    localparam logic [31:0] ERROR_RST  = 32'd10000000;

endpackage

@@ rtl/core/lrm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrm_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lrm_pkg::DIV_W-1:0]   dividend,
    input  logic [lrm_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [lrm_pkg::DIV_W-1:0]   quotient
);

    localparam int CNT_BITS = $clog2(lrm_pkg::DIV_W);
    localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(lrm_pkg::DIV_W - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic [lrm_pkg::DVS_W-1:0]   rem_reg;
    logic [lrm_pkg::DVS_W-1:0]   dvs_reg;
    logic [lrm_pkg::DIV_W-1:0]   quo_reg;

    logic [lrm_pkg::DVS_W:0]     trial;
    logic [lrm_pkg::DVS_W:0]     diff;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[lrm_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out at the top, the quotient in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[lrm_pkg::DVS_W-1:0] : trial[lrm_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[lrm_pkg::DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/lrm_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrm_mul
// Chunked multiplier: one narrow partial product per cycle, then accumulate.
// ----------------------------------------------------------------------------
module lrm_mul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lrm_pkg::MUL_W-1:0]   a,
    input  logic [lrm_pkg::MUL_W-1:0]   b,
    output logic                        done,
    output logic [lrm_pkg::PROD_W-1:0]  product
);

    localparam int CNT_BITS = $clog2(lrm_pkg::MUL_CHUNKS + 1);
    localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(lrm_pkg::MUL_CHUNKS);
    localparam int CW = lrm_pkg::MUL_CHUNK_W;

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic [lrm_pkg::MUL_W-1:0]   a_reg;
    logic [lrm_pkg::MUL_W-1:0]   b_reg;
    logic [lrm_pkg::PP_W-1:0]    pp_reg;
    logic [lrm_pkg::PROD_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Take b from its top chunk down; the accumulate adds pp_reg, registered in the cycle before
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg <= a_reg * b_reg[lrm_pkg::MUL_W-1 -: CW];
            b_reg  <= b_reg << CW;
            if (cnt_reg != '0)
            begin
                acc_reg <= (acc_reg << CW)
                         + {{(lrm_pkg::PROD_W - lrm_pkg::PP_W){1'b0}}, pp_reg};
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/core/loop_rate_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loop_rate_monitor
// Loop pacing monitor: awake time, Welford mean and M2, overrun counts and
// deadline schedule, computed by a sequencer around a serial divider and a
// chunked multiplier.
// ----------------------------------------------------------------------------
// Sequence: a step item runs ST_AWAKE, ST_DELTA, ST_DIV (radix-2 divider),
//   ST_MAG2, ST_MUL (chunked multiplier) and ST_DONE; a reset item goes to ST_DONE.
// A new item is taken only in ST_IDLE, after the last one has left ST_DONE.
// A waiting result is held in the output register while the next item enters.
// Reset: rst_n clears statistics, schedule and handshake state and loads the
//   default configuration.
// ----------------------------------------------------------------------------
module loop_rate_monitor
(
    input  logic           clk,
    input  logic           rst_n,
    // Input items
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [127:0]   s_tdata,   // entry_time_ns[62:0], check_time_ns[125:63], zero pad
    input  logic [0:0]     s_tuser,   // command[0]
    // Result items
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [311:0]   m_tdata,   // awake_ns[31:0], mean_q16[79:32], sum_sq_dev[143:80],
                                      // step_total[175:144], warn_total[207:176],
                                      // error_total[239:208], overrun_level[241:240],
                                      // sleep_needed[242], wake_time_ns[305:243], zero pad
    // Configuration
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    localparam int TW = lrm_pkg::TIME_W;
    localparam int MW = lrm_pkg::MEAN_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_AWAKE,
        ST_DELTA,
        ST_DIV,
        ST_MAG2,
        ST_MUL,
        ST_DONE
    } state_t;

    // Configuration
    logic [31:0]                    period_reg;
    logic [31:0]                    warn_lim_reg;
    logic [31:0]                    err_lim_reg;
    logic                           enforce_reg;

    // Sequencer and statistics
    state_t                         state_reg,    state_next;
    logic [TW-1:0]                  entry_reg,    entry_next;
    logic [TW-1:0]                  check_reg,    check_next;
    logic [lrm_pkg::CNT_W-1:0]      step_reg,     step_next;
    logic [lrm_pkg::CNT_W-1:0]      warn_reg,     warn_next;
    logic [lrm_pkg::CNT_W-1:0]      err_reg,      err_next;
    logic [MW-1:0]                  mean_reg,     mean_next;
    logic [lrm_pkg::M2_W-1:0]       m2_reg,       m2_next;
    logic [TW-1:0]                  last_reg,     last_next;
    logic [TW-1:0]                  dl_reg,       dl_next;
    logic [lrm_pkg::AWAKE_W-1:0]    awake_reg,    awake_next;
    logic [lrm_pkg::LEVEL_W-1:0]    level_reg,    level_next;
    logic                           sleep_reg,    sleep_next;
    logic                           neg1_reg,     neg1_next;
    logic [MW-1:0]                  mag1_reg,     mag1_next;
    logic                           neg2_reg,     neg2_next;
    logic [MW-1:0]                  mag2_reg,     mag2_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [311:0]                   m_tdata_reg,  m_tdata_next;

    // Datapath terms
    logic                           in_take;
    logic [TW-1:0]                  in_entry;
    logic [TW-1:0]                  in_check;
    logic [TW-1:0]                  awake_diff;
    logic [TW:0]                    dl_sum;
    logic [MW-1:0]                  x_val;
    logic                           x_below;
    logic [MW-1:0]                  x_mag;
    logic [lrm_pkg::M2_W-1:0]       prod;
    logic [lrm_pkg::M2_W:0]         m2_sum;
    logic                           m2_add;

    // Unit handshakes
    logic                           div_start;
    logic                           div_done;
    logic [lrm_pkg::DIV_W-1:0]      div_quo;
    logic                           mul_start;
    logic                           mul_done;
    logic [lrm_pkg::PROD_W-1:0]     mul_prod;

    assign in_take  = s_tvalid && s_tready;
    assign in_entry = s_tdata[TW-1:0];
    assign in_check = s_tdata[2*TW-1:TW];

    assign awake_diff = entry_reg - last_reg;
    assign dl_sum     = {1'b0, dl_reg} + {{(TW + 1 - 32){1'b0}}, period_reg};

    assign x_val   = {awake_reg, {lrm_pkg::FRAC_W{1'b0}}};
    assign x_below = (x_val < mean_reg);
    assign x_mag   = x_below ? (mean_reg - x_val) : (x_val - mean_reg);

    assign prod   = mul_prod[lrm_pkg::PROD_SHIFT +: lrm_pkg::M2_W];
    assign m2_sum = {1'b0, m2_reg} + {1'b0, prod};
    assign m2_add = (neg1_reg == neg2_reg) || (mag1_reg == '0) || (mag2_reg == '0);

    assign div_start = (state_reg == ST_DELTA);
    assign mul_start = (state_reg == ST_MAG2);

    lrm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_mag),
        .divisor  (step_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    lrm_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mag1_reg),
        .b       (x_mag),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        state_next    = state_reg;
        entry_next    = entry_reg;
        check_next    = check_reg;
        step_next     = step_reg;
        warn_next     = warn_reg;
        err_next      = err_reg;
        mean_next     = mean_reg;
        m2_next       = m2_reg;
        last_next     = last_reg;
        dl_next       = dl_reg;
        awake_next    = awake_reg;
        level_next    = level_reg;
        sleep_next    = sleep_reg;
        neg1_next     = neg1_reg;
        mag1_next     = mag1_reg;
        neg2_next     = neg2_reg;
        mag2_next     = mag2_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (!s_tuser[0])
                    begin
                        // Clear statistics and restart the schedule at now
                        step_next  = '0;
                        warn_next  = '0;
                        err_next   = '0;
                        mean_next  = '0;
                        m2_next    = '0;
                        last_next  = in_entry;
                        dl_next    = in_entry;
                        awake_next = '0;
                        level_next = lrm_pkg::LEVEL_OK;
                        sleep_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        entry_next = in_entry;
                        check_next = in_check;
                        state_next = ST_AWAKE;
                    end
                end
            end

            ST_AWAKE:
            begin
                if (entry_reg > last_reg)
                begin
                    awake_next = (|awake_diff[TW-1:lrm_pkg::AWAKE_W]) ? '1
                               : awake_diff[lrm_pkg::AWAKE_W-1:0];
                end
                else
                begin
                    awake_next = '0;
                end
                if (step_reg != '1)
                begin
                    step_next = step_reg + 1'b1;
                end
                dl_next    = dl_sum[TW] ? '1 : dl_sum[TW-1:0];
                state_next = ST_DELTA;
            end

            ST_DELTA:
            begin
                // Divider starts this cycle on |x - mean|
                neg1_next = x_below;
                mag1_next = x_mag;

                if (awake_reg > err_lim_reg)
                begin
                    level_next = lrm_pkg::LEVEL_ERROR;
                    if (err_reg != '1)
                    begin
                        err_next = err_reg + 1'b1;
                    end
                end
                else if (awake_reg > warn_lim_reg)
                begin
                    level_next = lrm_pkg::LEVEL_WARN;
                    if (warn_reg != '1)
                    begin
                        warn_next = warn_reg + 1'b1;
                    end
                end
                else
                begin
                    level_next = lrm_pkg::LEVEL_OK;
                end

                if (check_reg > dl_reg)
                begin
                    sleep_next = 1'b0;
                    last_next  = check_reg;
                    if (!enforce_reg)
                    begin
                        dl_next = check_reg;
                    end
                end
                else
                begin
                    sleep_next = 1'b1;
                    last_next  = dl_reg;
                end
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = neg1_reg ? (mean_reg - div_quo) : (mean_reg + div_quo);
                    state_next = ST_MAG2;
                end
            end

            ST_MAG2:
            begin
                // Multiplier starts this cycle on |x - new mean|
                neg2_next  = x_below;
                mag2_next  = x_mag;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (m2_add)
                    begin
                        m2_next = m2_sum[lrm_pkg::M2_W] ? '1 : m2_sum[lrm_pkg::M2_W-1:0];
                    end
                    else
                    begin
                        m2_next = (m2_reg > prod) ? (m2_reg - prod) : '0;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, dl_reg, sleep_reg, level_reg, err_reg, warn_reg,
                                     step_reg, m2_reg, mean_reg, awake_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            step_reg     <= '0;
            warn_reg     <= '0;
            err_reg      <= '0;
            mean_reg     <= '0;
            m2_reg       <= '0;
            last_reg     <= '0;
            dl_reg       <= '0;
            period_reg   <= lrm_pkg::PERIOD_RST;
            warn_lim_reg <= lrm_pkg::WARN_RST;
            err_lim_reg  <= lrm_pkg::ERROR_RST;
            enforce_reg  <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            step_reg     <= step_next;
            warn_reg     <= warn_next;
            err_reg      <= err_next;
            mean_reg     <= mean_next;
            m2_reg       <= m2_next;
            last_reg     <= last_next;
            dl_reg       <= dl_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lrm_pkg::REG_PERIOD:  period_reg   <= cfg_data;
                    lrm_pkg::REG_WARN:    warn_lim_reg <= cfg_data;
                    lrm_pkg::REG_ERROR:   err_lim_reg  <= cfg_data;
                    lrm_pkg::REG_ENFORCE: enforce_reg  <= cfg_data[0];
                    default:              enforce_reg  <= enforce_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        check_reg   <= check_next;
        awake_reg   <= awake_next;
        level_reg   <= level_next;
        sleep_reg   <= sleep_next;
        neg1_reg    <= neg1_next;
        mag1_reg    <= mag1_next;
        neg2_reg    <= neg2_next;
        mag2_reg    <= mag2_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
